### src/sha_pkg.sv
// Package for the SHA-256 stream hasher: round constants, initial hash values,
// shared types and the round and schedule functions. No dependencies.
package sha_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] word_t;

    // Command codes of the input channel.
    localparam logic CmdAbsorb = 1'b0;
    localparam logic CmdFinish = 1'b1;

    localparam logic [7:0] PadByte = 8'h80;

    // Queue entry between front and back.
    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } cmd_t;

    function automatic word_t initial_hash(input logic [2:0] idx);
        word_t r;
        begin
            case (idx)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                default: r = 32'h5be0cd19;
            endcase
            return r;
        end
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t r;
        begin
            case (idx)
                6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
                6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
                6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
                6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
                6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
                6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
                6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
                6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
                6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
                6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
                6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
                6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
                6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
                6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
                6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
                6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
                6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
                6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
                6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
                6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
                6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
                6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
                6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
                6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
                6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
                6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
                6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
                6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
                6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
                6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
                6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
                6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
            endcase
            return r;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        begin
            return (x >> n) | (x << (WordW - n));
        end
    endfunction

    function automatic word_t sig0(input word_t x);
        begin
            return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        end
    endfunction

    function automatic word_t sig1(input word_t x);
        begin
            return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
        end
    endfunction

    function automatic word_t bsig0(input word_t x);
        begin
            return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
        end
    endfunction

    function automatic word_t bsig1(input word_t x);
        begin
            return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
        end
    endfunction

endpackage

### src/sha_if.sv
// Handshake channel interfaces of the SHA-256 stream hasher.
// Depends on nothing; payload fields are plain logic vectors.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] message_byte;

    modport source (output valid, output command, output message_byte, input ready);
    modport sink   (input valid, input command, input message_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

### src/sha_queue.sv
// Short command queue between the front end and the compression engine.
// Depends on sha_pkg for the entry type.
module sha_queue #(
    parameter int unsigned Depth = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sha_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output sha_pkg::cmd_t pop_data,
    output logic          not_empty
);
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    sha_pkg::cmd_t      mem_reg [Depth];
    logic [AW-1:0]      wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]        cnt_reg, cnt_next;

    function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
        begin
            return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
        end
    endfunction

    assign full      = (cnt_reg == (AW+1)'(Depth));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? incr(wr_reg) : wr_reg;
        rd_next  = pop ? incr(rd_reg) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end
endmodule

### src/sha_engine.sv
// Back end of the SHA-256 hasher: block assembly, padding, the 64-round
// compression and digest output. Depends on sha_pkg and sha_if.
module sha_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  sha_pkg::cmd_t cmd_data,
    output logic          cmd_pop,
    sha_out_if.source     dout
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    sha_pkg::word_t     chain_reg [8];
    sha_pkg::word_t     v_reg [8];
    sha_pkg::word_t     w_reg [16];   // message words, then schedule window
    logic [63:0]        total_reg;
    logic [5:0]         pos_reg;      // byte position while padding
    logic [5:0]         rnd_reg;
    logic               fin_reg;      // the running block is the final one
    logic [2:0]         oidx_reg;
    logic               ovalid_reg;
    sha_pkg::word_t     oword_reg;
    logic               olast_reg;

    sha_pkg::word_t t1, t2, wnew, wcur;
    logic [63:0]    bits;
    logic [7:0]     pad_byte;

    assign bits = total_reg << 3;
    assign wcur = w_reg[0];
    assign wnew = sha_pkg::sig1(w_reg[14]) + w_reg[9] + sha_pkg::sig0(w_reg[1]) + w_reg[0];

    always_comb
    begin
        t1 = v_reg[7] + sha_pkg::bsig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha_pkg::round_k(rnd_reg) + wcur;
        t2 = sha_pkg::bsig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Padding byte for position pos_reg once the 0x80 marker is placed.
    always_comb
    begin
        pad_byte = 8'h00;
        if (fin_reg && pos_reg >= 6'd56)
        begin
            pad_byte = bits[(7 - (pos_reg - 6'd56)) * 8 +: 8];
        end
    end

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (cmd_valid)
                     begin
                         if (cmd_data.finish)
                             state_next = (total_reg[5:0] == 6'd63) ? S_LOAD : S_PAD;
                         else if (total_reg[5:0] == 6'd63) state_next = S_LOAD;
                     end
            S_PAD:   if (pos_reg == 6'd63) state_next = S_LOAD;
            S_LOAD:  state_next = S_ROUND;
            S_ROUND: if (rnd_reg == 6'd63) state_next = S_ADD;
            S_ADD:   state_next = fin_reg ? S_OUT : (total_reg[5:0] == 6'd0 ? S_IDLE : S_PAD);
            S_OUT:   if (ovalid_reg && dout.ready && olast_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign dout.valid       = ovalid_reg;
    assign dout.digest_word = oword_reg;
    assign dout.word_index  = oidx_reg;
    assign dout.last_word   = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            pos_reg    <= '0;
            rnd_reg    <= '0;
            fin_reg    <= 1'b0;
            oidx_reg   <= '0;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_pkg::initial_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd_data.finish)
                        begin
                            // Place the marker; fin_reg tells whether the length fits.
                            w_reg[total_reg[5:2]][(3 - total_reg[1:0]) * 8 +: 8] <=
                                sha_pkg::PadByte;
                            pos_reg <= total_reg[5:0] + 6'd1;
                            fin_reg <= (total_reg[5:0] < 6'd56);
                        end
                        else
                        begin
                            w_reg[total_reg[5:2]][(3 - total_reg[1:0]) * 8 +: 8] <=
                                cmd_data.data;
                            total_reg <= total_reg + 64'd1;
                            fin_reg   <= 1'b0;
                        end
                    end
                end
                S_PAD:
                begin
                    w_reg[pos_reg[5:2]][(3 - pos_reg[1:0]) * 8 +: 8] <= pad_byte;
                    pos_reg <= pos_reg + 6'd1;
                end
                S_LOAD:
                begin
                    for (int i = 0; i < 8; i++) v_reg[i] <= chain_reg[i];
                    rnd_reg <= '0;
                end
                S_ROUND:
                begin
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    rnd_reg <= rnd_reg + 6'd1;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
                    if (fin_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        oidx_reg   <= '0;
                        oword_reg  <= chain_reg[0] + v_reg[0];
                        olast_reg  <= 1'b0;
                    end
                    else if (total_reg[5:0] != 6'd0)
                    begin
                        // Overflow block of a finish: next block is zeros plus length.
                        pos_reg <= '0;
                        fin_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (ovalid_reg && dout.ready)
                    begin
                        if (olast_reg)
                        begin
                            ovalid_reg <= 1'b0;
                            total_reg  <= '0;
                            fin_reg    <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= sha_pkg::initial_hash(3'(i));
                            end
                        end
                        else
                        begin
                            oidx_reg  <= oidx_reg + 3'd1;
                            oword_reg <= chain_reg[oidx_reg + 3'd1];
                            olast_reg <= (oidx_reg == 3'd6);
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### src/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: input channel, command queue and
// compression engine. Depends on sha_pkg, sha_if, sha_queue and sha_engine.
//
// This block hashes a byte stream with SHA-256. Each input beat either absorbs
// one message byte (command 0) or finishes the message (command 1). The engine
// takes an absorb while idle; the beat completing a 64-byte block starts a
// compression (a load step, 64 rounds at one round per cycle, and a chaining
// add), during which no further bytes are taken from the queue. A finish writes
// the padding one byte per cycle up to the end of the block, compresses, and,
// when fewer than nine bytes were free, pads and compresses a second block; it
// then delivers the digest as eight output beats, word 0 first, with last_word
// set on the eighth. The chain and length counter then return to their start
// values. A queue of QueueDepth entries (four by default) sits in front of the
// engine, so the input keeps taking beats, until the queue is full, while a
// block is compressed or while the digest waits to be taken.
module sha256_stream_hasher #(
    parameter int unsigned QueueDepth = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    sha_in_if.sink     din,
    sha_out_if.source  dout
);
    sha_pkg::cmd_t push_data, pop_data;
    logic          full, not_empty, pop;

    assign din.ready        = !full;
    assign push_data.finish = din.command;
    assign push_data.data   = din.message_byte;

    sha_queue #(.Depth(QueueDepth)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (din.valid && !full),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    sha_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd_data  (pop_data),
        .cmd_pop   (pop),
        .dout      (dout)
    );
endmodule
